### rtl/core/segment_intersection_unit_defines.svh
// Assertion macros for the segment intersection unit.
// Used by segment_intersection_unit.sv; expects clk and rst_n in scope.
`ifndef SEGMENT_INTERSECTION_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SIU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/siu_pkg.sv
// Shared constants for the segment intersection unit.
// No dependencies; used by all modules of the unit.
package siu_pkg;

  localparam int unsigned COORD_WIDTH = 16;

endpackage

### rtl/core/siu_front.sv
// Front end: differences, cross products, determinant and hit test.
// Four register stages; depends on siu_pkg for the default width.
module siu_front #(
  parameter int unsigned W = siu_pkg::COORD_WIDTH
) (
  input  logic                  clk,
  input  logic [3:0]            en,
  input  logic signed [W-1:0]   x1,
  input  logic signed [W-1:0]   y1,
  input  logic signed [W-1:0]   x2,
  input  logic signed [W-1:0]   y2,
  input  logic signed [W-1:0]   x3,
  input  logic signed [W-1:0]   y3,
  input  logic signed [W-1:0]   x4,
  input  logic signed [W-1:0]   y4,
  output logic [2*W+2:0]        d_o,
  output logic [2*W+2:0]        tn_o,
  output logic                  hit_o,
  output logic signed [W-1:0]   a1x_o,
  output logic signed [W-1:0]   a1y_o,
  output logic [W:0]            mx_o,
  output logic [W:0]            my_o,
  output logic                  negx_o,
  output logic                  negy_o
);

  localparam int unsigned PW = 2 * W + 2;
  localparam int unsigned DW = 2 * W + 4;
  localparam int unsigned NW = DW - 1;

  typedef struct packed {
    logic signed [W-1:0] a1x;
    logic signed [W-1:0] a1y;
    logic [W:0]          mx;
    logic [W:0]          my;
    logic                negx;
    logic                negy;
  } side_t;

  logic signed [W:0]    x12_r, y12_r, x13_r, y13_r, x34_r, y34_r;
  logic signed [W:0]    x12_nxt, y12_nxt, x13_nxt, y13_nxt, x34_nxt, y34_nxt;
  side_t                s1_r, s2_r, s3_r, s4_r, s1_nxt;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [DW-1:0] d_r, tn_r, un_r;
  logic signed [DW-1:0] dn, tnn, unn;
  logic [NW-1:0]        d4_r, tn4_r;
  logic                 hit4_r, hit_nxt;

  always_comb begin
    x12_nxt = (W+1)'(x1) - (W+1)'(x2);
    y12_nxt = (W+1)'(y1) - (W+1)'(y2);
    x13_nxt = (W+1)'(x1) - (W+1)'(x3);
    y13_nxt = (W+1)'(y1) - (W+1)'(y3);
    x34_nxt = (W+1)'(x3) - (W+1)'(x4);
    y34_nxt = (W+1)'(y3) - (W+1)'(y4);
    s1_nxt.a1x  = x1;
    s1_nxt.a1y  = y1;
    s1_nxt.mx   = x12_nxt[W] ? (W+1)'(-x12_nxt) : (W+1)'(x12_nxt);
    s1_nxt.my   = y12_nxt[W] ? (W+1)'(-y12_nxt) : (W+1)'(y12_nxt);
    s1_nxt.negx = !x12_nxt[W] && (x12_nxt != '0);
    s1_nxt.negy = !y12_nxt[W] && (y12_nxt != '0);
  end

  always_comb begin
    dn  = d_r[DW-1] ? -d_r  : d_r;
    tnn = d_r[DW-1] ? -tn_r : tn_r;
    unn = d_r[DW-1] ? -un_r : un_r;
    hit_nxt = (dn != '0) && !tnn[DW-1] && !unn[DW-1] && (tnn <= dn) && (unn <= dn);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x12_r <= x12_nxt;
      y12_r <= y12_nxt;
      x13_r <= x13_nxt;
      y13_r <= y13_nxt;
      x34_r <= x34_nxt;
      y34_r <= y34_nxt;
      s1_r  <= s1_nxt;
    end
    if (en[1]) begin
      p1_r <= PW'(x12_r) * PW'(y34_r);
      p2_r <= PW'(y12_r) * PW'(x34_r);
      p3_r <= PW'(x13_r) * PW'(y34_r);
      p4_r <= PW'(y13_r) * PW'(x34_r);
      p5_r <= PW'(x13_r) * PW'(y12_r);
      p6_r <= PW'(y13_r) * PW'(x12_r);
      s2_r <= s1_r;
    end
    if (en[2]) begin
      d_r  <= DW'(p1_r) - DW'(p2_r);
      tn_r <= DW'(p3_r) - DW'(p4_r);
      un_r <= DW'(p5_r) - DW'(p6_r);
      s3_r <= s2_r;
    end
    if (en[3]) begin
      d4_r   <= dn[NW-1:0];
      tn4_r  <= tnn[NW-1:0];
      hit4_r <= hit_nxt;
      s4_r   <= s3_r;
    end
  end

  assign d_o    = d4_r;
  assign tn_o   = tn4_r;
  assign hit_o  = hit4_r;
  assign a1x_o  = s4_r.a1x;
  assign a1y_o  = s4_r.a1y;
  assign mx_o   = s4_r.mx;
  assign my_o   = s4_r.my;
  assign negx_o = s4_r.negx;
  assign negy_o = s4_r.negy;

endmodule

### rtl/core/siu_div_step.sv
// One digit stage of the interpolation divider for both coordinates.
// Forms floor(|delta| * tn / d) one bit of |delta| per stage; uses siu_pkg.
module siu_div_step #(
  parameter int unsigned W   = siu_pkg::COORD_WIDTH,
  parameter int unsigned BIT = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*W+2:0]      d_i,
  input  logic [2*W+2:0]      tn_i,
  input  logic                hit_i,
  input  logic signed [W-1:0] a1x_i,
  input  logic signed [W-1:0] a1y_i,
  input  logic [W:0]          mx_i,
  input  logic [W:0]          my_i,
  input  logic                negx_i,
  input  logic                negy_i,
  input  logic [2*W+2:0]      rx_i,
  input  logic [2*W+2:0]      ry_i,
  input  logic [W+1:0]        qx_i,
  input  logic [W+1:0]        qy_i,
  output logic [2*W+2:0]      d_o,
  output logic [2*W+2:0]      tn_o,
  output logic                hit_o,
  output logic signed [W-1:0] a1x_o,
  output logic signed [W-1:0] a1y_o,
  output logic [W:0]          mx_o,
  output logic [W:0]          my_o,
  output logic                negx_o,
  output logic                negy_o,
  output logic [2*W+2:0]      rx_o,
  output logic [2*W+2:0]      ry_o,
  output logic [W+1:0]        qx_o,
  output logic [W+1:0]        qy_o
);

  localparam int unsigned NW = 2 * W + 3;
  localparam int unsigned RW = NW + 2;

  logic [RW-1:0] tx, ty, remx, remy, d1, d2;
  logic [1:0]    digx, digy;

  always_comb begin
    d1 = RW'(d_i);
    d2 = RW'({d_i, 1'b0});
    tx = RW'({rx_i, 1'b0}) + (mx_i[BIT] ? RW'(tn_i) : '0);
    ty = RW'({ry_i, 1'b0}) + (my_i[BIT] ? RW'(tn_i) : '0);
    if (tx >= d2) begin
      remx = tx - d2;
      digx = 2'd2;
    end else if (tx >= d1) begin
      remx = tx - d1;
      digx = 2'd1;
    end else begin
      remx = tx;
      digx = 2'd0;
    end
    if (ty >= d2) begin
      remy = ty - d2;
      digy = 2'd2;
    end else if (ty >= d1) begin
      remy = ty - d1;
      digy = 2'd1;
    end else begin
      remy = ty;
      digy = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o    <= d_i;
      tn_o   <= tn_i;
      hit_o  <= hit_i;
      a1x_o  <= a1x_i;
      a1y_o  <= a1y_i;
      mx_o   <= mx_i;
      my_o   <= my_i;
      negx_o <= negx_i;
      negy_o <= negy_i;
      rx_o   <= remx[NW-1:0];
      ry_o   <= remy[NW-1:0];
      qx_o   <= {qx_i[W:0], 1'b0} + (W+2)'(digx);
      qy_o   <= {qy_i[W:0], 1'b0} + (W+2)'(digy);
    end
  end

endmodule

### rtl/core/siu_round.sv
// Final stage: applies the quotient to the start point and rounds to nearest.
// Ties go away from zero; a miss gives a zero point. Uses siu_pkg.
module siu_round #(
  parameter int unsigned W = siu_pkg::COORD_WIDTH
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*W+2:0]      d_i,
  input  logic                hit_i,
  input  logic signed [W-1:0] a1x_i,
  input  logic signed [W-1:0] a1y_i,
  input  logic                negx_i,
  input  logic                negy_i,
  input  logic [2*W+2:0]      rx_i,
  input  logic [2*W+2:0]      ry_i,
  input  logic [W+1:0]        qx_i,
  input  logic [W+1:0]        qy_i,
  output logic                hit_o,
  output logic signed [W-1:0] px_o,
  output logic signed [W-1:0] py_o
);

  localparam int unsigned NW = 2 * W + 3;
  localparam int unsigned BW = W + 3;

  function automatic logic [W-1:0] rnd(input logic signed [W-1:0] a1, input logic [W+1:0] q,
                                       input logic neg, input logic [NW-1:0] r,
                                       input logic [NW-1:0] d);
    logic signed [BW-1:0] qs;
    logic signed [BW-1:0] base;
    logic [NW:0]          r2;
    logic [NW:0]          dd;
    qs   = signed'(BW'(q));
    base = BW'(a1) + (neg ? -qs : qs);
    r2   = {r, 1'b0};
    dd   = {1'b0, d};
    if (r != '0) begin
      if (r2 != dd) begin
        if (r2 > dd) begin
          base = neg ? base - BW'(1) : base + BW'(1);
        end
      end else if (!neg) begin
        if (!base[BW-1]) begin
          base = base + BW'(1);
        end
      end else begin
        if (base[BW-1] || (base == '0)) begin
          base = base - BW'(1);
        end
      end
    end
    return base[W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      hit_o <= hit_i;
      px_o  <= hit_i ? signed'(rnd(a1x_i, qx_i, negx_i, rx_i, d_i)) : '0;
      py_o  <= hit_i ? signed'(rnd(a1y_i, qy_i, negy_i, ry_i, d_i)) : '0;
    end
  end

endmodule

### rtl/core/segment_intersection_unit.sv
// Top level of the segment intersection unit: front end, divider chain, rounding.
// Depends on siu_pkg, siu_front, siu_div_step, siu_round and the defines header.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  a and b segment endpoints
//   out_      output     out_valid/out_stall  hit, point_x, point_y
//
// One transfer per cycle is accepted while in_stall is low.
// Four front stages form the determinant, COORD_WIDTH + 1 divider stages each
// resolve one bit of the segment delta, and a rounding stage drives the outputs.
// Reset clears only the stage valid bits. A stall moves data into empty stages and
// holds full stages with no empty stage ahead, so nothing is dropped or repeated.
`include "segment_intersection_unit_defines.svh"

module segment_intersection_unit #(
  parameter int unsigned COORD_WIDTH = siu_pkg::COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_a_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned NW = 2 * W + 3;
  localparam int unsigned ND = W + 1;
  localparam int unsigned NS = 4 + ND + 1;

  logic [NS-1:0] valid_r, valid_nxt, valid_in;
  logic [NS:0]   rdy;

  logic [NW-1:0]        d_a    [ND+1];
  logic [NW-1:0]        tn_a   [ND+1];
  logic                 hit_a  [ND+1];
  logic signed [W-1:0]  a1x_a  [ND+1];
  logic signed [W-1:0]  a1y_a  [ND+1];
  logic [W:0]           mx_a   [ND+1];
  logic [W:0]           my_a   [ND+1];
  logic                 negx_a [ND+1];
  logic                 negy_a [ND+1];
  logic [NW-1:0]        rx_a   [ND+1];
  logic [NW-1:0]        ry_a   [ND+1];
  logic [W+1:0]         qx_a   [ND+1];
  logic [W+1:0]         qy_a   [ND+1];

  always_comb begin
    rdy[NS] = !out_stall;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !valid_r[i] || rdy[i+1];
    end
    valid_in = {valid_r[NS-2:0], in_valid};
    for (int i = 0; i < NS; i++) begin
      valid_nxt[i] = rdy[i] ? valid_in[i] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = valid_r[NS-1];

  siu_front #(.W(W)) u_front (
    .clk    (clk),
    .en     (rdy[3:0]),
    .x1     (in_a_start_x),
    .y1     (in_a_start_y),
    .x2     (in_a_end_x),
    .y2     (in_a_end_y),
    .x3     (in_b_start_x),
    .y3     (in_b_start_y),
    .x4     (in_b_end_x),
    .y4     (in_b_end_y),
    .d_o    (d_a[0]),
    .tn_o   (tn_a[0]),
    .hit_o  (hit_a[0]),
    .a1x_o  (a1x_a[0]),
    .a1y_o  (a1y_a[0]),
    .mx_o   (mx_a[0]),
    .my_o   (my_a[0]),
    .negx_o (negx_a[0]),
    .negy_o (negy_a[0])
  );

  assign rx_a[0] = '0;
  assign ry_a[0] = '0;
  assign qx_a[0] = '0;
  assign qy_a[0] = '0;

  for (genvar k = 0; k < ND; k++) begin : g_div
    siu_div_step #(.W(W), .BIT(ND - 1 - k)) u_step (
      .clk    (clk),
      .en     (rdy[4+k]),
      .d_i    (d_a[k]),
      .tn_i   (tn_a[k]),
      .hit_i  (hit_a[k]),
      .a1x_i  (a1x_a[k]),
      .a1y_i  (a1y_a[k]),
      .mx_i   (mx_a[k]),
      .my_i   (my_a[k]),
      .negx_i (negx_a[k]),
      .negy_i (negy_a[k]),
      .rx_i   (rx_a[k]),
      .ry_i   (ry_a[k]),
      .qx_i   (qx_a[k]),
      .qy_i   (qy_a[k]),
      .d_o    (d_a[k+1]),
      .tn_o   (tn_a[k+1]),
      .hit_o  (hit_a[k+1]),
      .a1x_o  (a1x_a[k+1]),
      .a1y_o  (a1y_a[k+1]),
      .mx_o   (mx_a[k+1]),
      .my_o   (my_a[k+1]),
      .negx_o (negx_a[k+1]),
      .negy_o (negy_a[k+1]),
      .rx_o   (rx_a[k+1]),
      .ry_o   (ry_a[k+1]),
      .qx_o   (qx_a[k+1]),
      .qy_o   (qy_a[k+1])
    );
  end

  siu_round #(.W(W)) u_round (
    .clk    (clk),
    .en     (rdy[NS-1]),
    .d_i    (d_a[ND]),
    .hit_i  (hit_a[ND]),
    .a1x_i  (a1x_a[ND]),
    .a1y_i  (a1y_a[ND]),
    .negx_i (negx_a[ND]),
    .negy_i (negy_a[ND]),
    .rx_i   (rx_a[ND]),
    .ry_i   (ry_a[ND]),
    .qx_i   (qx_a[ND]),
    .qy_i   (qy_a[ND]),
    .hit_o  (out_hit),
    .px_o   (out_point_x),
    .py_o   (out_point_y)
  );

  `SIU_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, (out_point_x == '0) && (out_point_y == '0), "miss with nonzero point")
  `SIU_ASSERT_NOW(a_stall_full, in_stall, (valid_r == '1) && out_stall, "input stalled with room in the pipeline")
  `SIU_ASSERT_NEXT(a_drain, !out_stall && !in_valid && (valid_r[NS-2:0] == '0), !out_valid, "unexpected output transfer")

endmodule

### tb/sv/segment_intersection_unit_test.sv
// Testbench for segment_intersection_unit: drives segment pairs, predicts hit and point.
// Depends on siu_pkg and the segment_intersection_unit RTL; needs no other files.
module segment_intersection_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = siu_pkg::COORD_WIDTH;
  localparam int LATENCY = W + 6;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [W-1:0] coord_t;
  typedef struct packed {
    coord_t ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  } seg_pair_t;
  typedef struct packed {
    logic   hit;
    coord_t px, py;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_a_start_x = '0, in_a_start_y = '0, in_a_end_x = '0, in_a_end_y = '0;
  coord_t in_b_start_x = '0, in_b_start_y = '0, in_b_end_x = '0, in_b_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  coord_t out_point_x, out_point_y;

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_cycles = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit stimulus_done = 1'b0;

  segment_intersection_unit dut (.*);

  always #5 clk = ~clk;

  function automatic longint nearest_div(longint num, longint den);
    longint q, r;
    q = num / den;
    r = num % den;
    if (r < 0) r = -r;
    if (2 * r >= den) q += (num < 0) ? -1 : 1;
    return q;
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t s);
    crossing_t c;
    longint x1, y1, x2, y2, x3, y3, x4, y4, det, tnum, unum;
    c = '0;
    x1 = s.ax1; y1 = s.ay1; x2 = s.ax2; y2 = s.ay2;
    x3 = s.bx1; y3 = s.by1; x4 = s.bx2; y4 = s.by2;
    det = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    tnum = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
    unum = (x1 - x3) * (y1 - y2) - (y1 - y3) * (x1 - x2);
    if (det != 0) begin
      if (det < 0) begin
        det = -det; tnum = -tnum; unum = -unum;
      end
      if (tnum >= 0 && unum >= 0 && tnum <= det && unum <= det) begin
        c.hit = 1'b1;
        c.px = coord_t'(nearest_div(x1 * det + tnum * (x2 - x1), det));
        c.py = coord_t'(nearest_div(y1 * det + tnum * (y2 - y1), det));
      end
    end
    return c;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 255)) - 128;
      default: return coord_t'($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  task automatic queue_pair(seg_pair_t s);
    pending_pairs.push_back(s);
  endtask

  task automatic queue_random_pairs(int count);
    seg_pair_t s;
    coord_t mx, my;
    int mode;
    repeat (count) begin
      mode = $urandom_range(0, 2);
      s = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
           rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
      if ($urandom_range(0, 99) < 45) begin
        // Bias toward a crossing: B's endpoints straddle A's midpoint, up-left and down-right.
        mx = coord_t'((longint'(s.ax1) + longint'(s.ax2)) / 2);
        my = coord_t'((longint'(s.ay1) + longint'(s.ay2)) / 2);
        s.bx1 = mx - coord_t'($urandom_range(0, 200));
        s.by1 = my + coord_t'($urandom_range(0, 200));
        s.bx2 = mx + coord_t'($urandom_range(0, 200));
        s.by2 = my - coord_t'($urandom_range(0, 200));
      end else if ($urandom_range(0, 9) == 0) begin
        s.bx1 = s.ax2; s.by1 = s.ay2;
      end
      queue_pair(s);
    end
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || expected_crossings.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        seg_pair_t s;
        s = pending_pairs.pop_front();
        expected_crossings.push_back(predict_crossing(s));
        in_valid <= 1'b1;
        {in_a_start_x, in_a_start_y, in_a_end_x, in_a_end_y,
         in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y} <= s;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_crossings.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MAX_REPORTS) $display("Unexpected result transfer.");
        end else begin
          crossing_t e;
          e = expected_crossings.pop_front();
          if (e.hit !== out_hit || e.px !== out_point_x || e.py !== out_point_y) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < MAX_REPORTS)
              $display("Mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                       e.hit, e.px, e.py, out_hit, out_point_x, out_point_y);
          end
        end
      end
    end
  end

  initial begin
    coord_t mx, mn;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    queue_pair('{0, 0, 160, 160, 0, 160, 160, 0});
    queue_pair('{0, 0, 160, 0, 0, 16, 160, 16});
    queue_pair('{0, 0, 160, 0, 16, 0, 320, 0});
    queue_pair('{16, 16, 16, 16, 0, 0, 32, 32});
    queue_pair('{0, 0, 160, 0, 160, 0, 160, 160});
    queue_pair('{0, 0, 160, 0, 0, 0, 0, 160});
    queue_pair('{0, 0, 160, 0, 80, -80, 80, 80});
    queue_pair('{0, 0, 160, 0, 200, -80, 200, 80});
    queue_pair('{0, 0, 3, 0, 1, -1, 2, 1});
    queue_pair('{0, 0, -3, 0, -1, -1, -2, 1});
    queue_pair('{0, 0, 1, 0, 0, -1, 1, 1});
    queue_pair('{0, 0, -1, 0, 0, -1, -1, 1});
    queue_pair('{-3, 0, 0, 0, -1, -1, -2, 1});
    queue_pair('{3, 0, 0, 0, 1, -1, 2, 1});
    queue_pair('{mn, mn, mx, mx, mn, mx, mx, mn});
    queue_pair('{mx, mn, mn, mx, mx, mx, mn, mn});
    queue_pair('{mn, 0, mx, 0, 0, mn, 0, mx});
    queue_pair('{mx, mx, mn, mn, mx, mx, mn, mx});
    queue_pair('{-1, -1, -1, -1, -1, -1, -1, -1});
    queue_pair('{0, 0, 7, 3, 5, -2, 1, 9});
    queue_random_pairs(200);
    wait_drained();
    send_idle_pct = 64;
    queue_random_pairs(300);
    wait_drained();
    send_idle_pct = 0;
    stall_pct = 64;
    queue_random_pairs(300);
    wait_drained();
    stall_pct = 36;
    send_idle_pct = 36;
    queue_random_pairs(300);
    wait_drained();
    stall_pct = 0;
    send_idle_pct = 0;
    hold_off_cycles = 200;
    queue_random_pairs(300);
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk);
    stimulus_done = 1'b1;
    if (mismatch_count == 0 && expected_crossings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
